### rtl/sor_pkg.sv
// Shared types and codes for the segment offset remapper.
package sor_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_ACCESS = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_SKIP = 2'd2;
    localparam logic [1:0] KIND_POS  = 2'd3;

    typedef enum logic [2:0] {
        ST_FORWARD     = 3'd0,
        ST_ZERO_READ   = 3'd1,
        ST_WRITE_FAULT = 3'd2,
        ST_FULL        = 3'd3,
        ST_ACCEPTED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WALK,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic valid;
        logic done;
        logic bounded;
        logic is_data;
    } tok_ctl_t;

endpackage

### rtl/sor_cell.sv
// One table cell: holds a segment and passes the lookup token to its neighbor.
module sor_cell
    import sor_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int CNT_W       = 5,
    parameter int OFFSET_BITS = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CNT_W-1:0]       count,
    input  logic [OFFSET_BITS-1:0] start,
    input  logic                   wr_en,
    input  logic [OFFSET_BITS-1:0] wr_src,
    input  logic [OFFSET_BITS-1:0] wr_map,
    input  logic                   wr_is_data,
    input  logic [OFFSET_BITS-1:0] nxt_map,
    output logic [OFFSET_BITS-1:0] map_base,
    input  tok_ctl_t               tin_ctl,
    input  logic [OFFSET_BITS-1:0] tin_src,
    input  logic [OFFSET_BITS-1:0] tin_map,
    input  logic [OFFSET_BITS-1:0] tin_bound,
    output tok_ctl_t               tout_ctl,
    output logic [OFFSET_BITS-1:0] tout_src,
    output logic [OFFSET_BITS-1:0] tout_map,
    output logic [OFFSET_BITS-1:0] tout_bound
);

    localparam logic [CNT_W:0] NEXT_IDX = (CNT_W+1)'(IDX + 1);

    logic [OFFSET_BITS-1:0] src_reg;
    logic [OFFSET_BITS-1:0] map_reg;
    logic                   data_reg;
    tok_ctl_t               ctl_reg;
    tok_ctl_t               ctl_next;
    logic [OFFSET_BITS-1:0] tsrc_reg;
    logic [OFFSET_BITS-1:0] tsrc_next;
    logic [OFFSET_BITS-1:0] tmap_reg;
    logic [OFFSET_BITS-1:0] tmap_next;
    logic [OFFSET_BITS-1:0] tbnd_reg;
    logic [OFFSET_BITS-1:0] tbnd_next;
    logic                   next_used;
    logic                   take;

    assign map_base  = map_reg;
    assign next_used = {1'b0, count} > NEXT_IDX;
    assign take      = tin_ctl.valid && !tin_ctl.done && (!next_used || (start < nxt_map));

    always_comb
    begin
        ctl_next.valid   = tin_ctl.valid;
        ctl_next.done    = tin_ctl.done || take;
        ctl_next.bounded = take ? next_used : tin_ctl.bounded;
        ctl_next.is_data = take ? data_reg : tin_ctl.is_data;
        tsrc_next        = take ? src_reg : tin_src;
        tmap_next        = take ? map_reg : tin_map;
        tbnd_next        = take ? nxt_map : tin_bound;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_reg  <= wr_src;
            map_reg  <= wr_map;
            data_reg <= wr_is_data;
        end
        tsrc_reg <= tsrc_next;
        tmap_reg <= tmap_next;
        tbnd_reg <= tbnd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign tout_ctl   = ctl_reg;
    assign tout_src   = tsrc_reg;
    assign tout_map   = tmap_reg;
    assign tout_bound = tbnd_reg;

endmodule

### rtl/segment_offset_remapper.sv
// Top level of the segment offset remapper: command decode, cursors, cell chain, result register.
//
// Clear, append and the unused command go from S_IDLE straight to S_HOLD; an
// access on a non-empty table passes through S_LAUNCH, S_WALK and S_HOLD before
// the next request can be taken, with the lookup token stepping one cell per cycle
// through the chain of MAX_SEGMENTS segment cells. An access on an empty table goes
// straight to S_HOLD. A result waiting on rsp_stall blocks the next request.
module segment_offset_remapper
    import sor_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int OFFSET_BITS  = 48,
    parameter int LENGTH_BITS  = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [1:0]             cmd,
    input  logic [1:0]             seg_kind,
    input  logic [OFFSET_BITS-1:0] seg_length,
    input  logic                   is_write,
    input  logic [OFFSET_BITS-1:0] start_offset,
    input  logic [LENGTH_BITS-1:0] access_length,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [2:0]             status,
    output logic [OFFSET_BITS-1:0] target_offset,
    output logic [LENGTH_BITS-1:0] clipped_length
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W = (OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [OFFSET_BITS-1:0] src_cur_reg;
    logic [OFFSET_BITS-1:0] src_cur_next;
    logic [OFFSET_BITS-1:0] map_cur_reg;
    logic [OFFSET_BITS-1:0] map_cur_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic                   wr_reg;
    status_t                res_status_reg;
    status_t                res_status_next;
    logic [OFFSET_BITS-1:0] res_tgt_reg;
    logic [OFFSET_BITS-1:0] res_tgt_next;
    logic [LENGTH_BITS-1:0] res_len_reg;
    logic [LENGTH_BITS-1:0] res_len_next;
    status_t                imm_status;
    logic [OFFSET_BITS-1:0] imm_tgt;
    logic [LENGTH_BITS-1:0] imm_len;
    logic                   rsp_valid_reg;
    status_t                out_status_reg;
    logic [OFFSET_BITS-1:0] out_tgt_reg;
    logic [LENGTH_BITS-1:0] out_len_reg;
    logic                   req_fire;
    logic                   out_free;
    logic                   launch;
    logic                   walk_done;
    logic                   emit;
    logic                   seg_store;
    logic                   seg_is_data;
    logic                   go_walk;

    tok_ctl_t               ctl_w  [MAX_SEGMENTS+1];
    logic [OFFSET_BITS-1:0] tsrc_w [MAX_SEGMENTS+1];
    logic [OFFSET_BITS-1:0] tmap_w [MAX_SEGMENTS+1];
    logic [OFFSET_BITS-1:0] tbnd_w [MAX_SEGMENTS+1];
    logic [OFFSET_BITS-1:0] base_w [MAX_SEGMENTS+1];
    logic [MAX_SEGMENTS-1:0] tok_valid_vec;

    logic [OFFSET_BITS-1:0] room;
    logic [OFFSET_BITS-1:0] xlat;
    logic [LENGTH_BITS-1:0] cut_len;
    tok_ctl_t               last_ctl;

    assign req_fire = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign go_walk  = (cmd == CMD_ACCESS) && (count_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = go_walk ? S_LAUNCH : S_HOLD;
                end
            end
            S_LAUNCH: state_next = S_WALK;
            S_WALK:
            begin
                if (last_ctl.valid)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall = 1'b1;
        launch    = 1'b0;
        walk_done = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            S_IDLE:   req_stall = 1'b0;
            S_LAUNCH: launch = 1'b1;
            S_WALK:   walk_done = last_ctl.valid;
            S_HOLD:   emit = out_free;
            default:  req_stall = 1'b1;
        endcase
    end

    // command decode and cursor update
    always_comb
    begin
        count_next   = count_reg;
        src_cur_next = src_cur_reg;
        map_cur_next = map_cur_reg;
        seg_store    = 1'b0;
        seg_is_data  = 1'b0;
        imm_status   = ST_ACCEPTED;
        imm_tgt      = '0;
        imm_len      = '0;
        unique case (cmd)
            CMD_CLEAR:
            begin
                count_next   = '0;
                src_cur_next = '0;
                map_cur_next = '0;
            end
            CMD_APPEND:
            begin
                case (seg_kind) inside
                    KIND_POS:  src_cur_next = seg_length;
                    KIND_SKIP: src_cur_next = src_cur_reg + seg_length;
                    KIND_DATA, KIND_ZERO:
                    begin
                        if (count_reg < CNT_MAX)
                        begin
                            seg_store    = 1'b1;
                            seg_is_data  = (seg_kind == KIND_DATA);
                            count_next   = count_reg + CNT_W'(1);
                            map_cur_next = map_cur_reg + seg_length;
                            if (seg_kind == KIND_DATA)
                            begin
                                src_cur_next = src_cur_reg + seg_length;
                            end
                        end
                        else
                        begin
                            imm_status = ST_FULL;
                        end
                    end
                    default: imm_status = ST_ACCEPTED;
                endcase
            end
            CMD_ACCESS:
            begin
                imm_status = is_write ? ST_WRITE_FAULT : ST_ZERO_READ;
                imm_tgt    = is_write ? '0 : start_offset;
                imm_len    = access_length;
            end
            default: imm_status = ST_ACCEPTED;
        endcase
    end

    // cell chain
    assign ctl_w[0].valid   = launch;
    assign ctl_w[0].done    = 1'b0;
    assign ctl_w[0].bounded = 1'b0;
    assign ctl_w[0].is_data = 1'b0;
    assign tsrc_w[0]        = '0;
    assign tmap_w[0]        = '0;
    assign tbnd_w[0]        = '0;
    assign base_w[MAX_SEGMENTS] = '0;

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        sor_cell #(
            .IDX         (i),
            .CNT_W       (CNT_W),
            .OFFSET_BITS (OFFSET_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (count_reg),
            .start      (start_reg),
            .wr_en      (req_fire && seg_store && (count_reg == CNT_W'(i))),
            .wr_src     (src_cur_reg),
            .wr_map     (map_cur_reg),
            .wr_is_data (seg_is_data),
            .nxt_map    (base_w[i+1]),
            .map_base   (base_w[i]),
            .tin_ctl    (ctl_w[i]),
            .tin_src    (tsrc_w[i]),
            .tin_map    (tmap_w[i]),
            .tin_bound  (tbnd_w[i]),
            .tout_ctl   (ctl_w[i+1]),
            .tout_src   (tsrc_w[i+1]),
            .tout_map   (tmap_w[i+1]),
            .tout_bound (tbnd_w[i+1])
        );
        assign tok_valid_vec[i] = ctl_w[i+1].valid;
    end

    assign last_ctl = ctl_w[MAX_SEGMENTS];

    // clip and translate
    always_comb
    begin
        room = tbnd_w[MAX_SEGMENTS] - start_reg;
        xlat = start_reg - tmap_w[MAX_SEGMENTS] + tsrc_w[MAX_SEGMENTS];
        if (last_ctl.bounded && (CMP_W'(len_reg) > CMP_W'(room)))
        begin
            cut_len = LENGTH_BITS'(CMP_W'(room));
        end
        else
        begin
            cut_len = len_reg;
        end
    end

    always_comb
    begin
        res_status_next = res_status_reg;
        res_tgt_next    = res_tgt_reg;
        res_len_next    = res_len_reg;
        if (req_fire)
        begin
            res_status_next = imm_status;
            res_tgt_next    = imm_tgt;
            res_len_next    = imm_len;
        end
        else if (walk_done)
        begin
            res_len_next = cut_len;
            if (last_ctl.is_data)
            begin
                res_status_next = ST_FORWARD;
                res_tgt_next    = xlat;
            end
            else if (wr_reg)
            begin
                res_status_next = ST_WRITE_FAULT;
                res_tgt_next    = '0;
            end
            else
            begin
                res_status_next = ST_ZERO_READ;
                res_tgt_next    = xlat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            start_reg <= start_offset;
            len_reg   <= access_length;
            wr_reg    <= is_write;
        end
        res_status_reg <= res_status_next;
        res_tgt_reg    <= res_tgt_next;
        res_len_reg    <= res_len_next;
        if (emit)
        begin
            out_status_reg <= res_status_reg;
            out_tgt_reg    <= res_tgt_reg;
            out_len_reg    <= res_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            src_cur_reg   <= '0;
            map_cur_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                count_reg   <= count_next;
                src_cur_reg <= src_cur_next;
                map_cur_reg <= map_cur_next;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = out_status_reg;
    assign target_offset  = out_tgt_reg;
    assign clipped_length = out_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("segment count beyond capacity");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one lookup token in the cell chain");

    a_token_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        last_ctl.valid |-> (state_reg == S_WALK) && last_ctl.done)
        else $error("lookup token left the chain outside a walk or unresolved");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (cmd == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

endmodule
